// ===== rtl/telnet_iac_option_negotiator_unit_macros.svh =====
// Assertion macros for the telnet option negotiator.
`ifndef TELNET_IAC_OPTION_NEGOTIATOR_UNIT_MACROS_SVH
`define TELNET_IAC_OPTION_NEGOTIATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TIO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TIO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tio_pkg.sv =====
package tio_pkg;
  localparam int SubDepth  = 40;
  localparam int SubIdxW   = 6;
  localparam int TypeChars = 8;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_GA   = 8'd249;
  localparam logic [7:0] B_BRK  = 8'd243;
  localparam logic [7:0] B_DM   = 8'd242;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] OPT_SPEED  = 8'd32;
  localparam logic [7:0] SUB_IS     = 8'd0;
  localparam logic [7:0] SUB_SEND   = 8'd1;
  localparam logic [23:0] SpeedMax     = 24'd9999999;
  localparam logic [23:0] DefaultSpeed = 24'd9600;

  localparam logic [2:0] K_DATA   = 3'd0;
  localparam logic [2:0] K_NET    = 3'd1;
  localparam logic [2:0] K_WIN    = 3'd2;
  localparam logic [2:0] K_LBRK   = 3'd3;
  localparam logic [2:0] K_RBRK   = 3'd4;
  localparam logic [2:0] K_UNEXP  = 3'd5;

  localparam logic [1:0] REG_BREAK_MODE = 2'd0;
  localparam logic [1:0] REG_TYPE_CHARS = 2'd1;
  localparam logic [1:0] REG_TYPE_LEN   = 2'd2;
  localparam logic [1:0] REG_SPEED      = 2'd3;

  // Reply sequencer source selection.
  typedef enum logic [2:0] {
    SRC_IAC, SRC_SB, SRC_OPT, SRC_IS, SRC_CHAR, SRC_DIGIT, SRC_COMMA, SRC_SE
  } src_e;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       load_byte;   // capture rx byte into parse stage
    logic       sub_clear;
    logic       sub_write;
    logic       sub_read;    // read address from rd_idx
    logic [SubIdxW-1:0] rd_idx;
    logic       conv_start;  // start decimal conversion
    logic       conv_step;
    logic       win_latch;   // shift read byte into window register
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       conv_done;
    logic [3:0] ndig;
  } dp_sts_t;
endpackage

// ===== rtl/tio_datapath.sv =====
// Subnegotiation buffer, decimal converter and window size register.
module tio_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tio_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        wr_data_i,
  input  logic [tio_pkg::SubIdxW-1:0] wr_idx_i,
  input  logic [23:0]       speed_i,
  input  logic [2:0]        dig_sel_i,
  output logic [7:0]        dig_char_o,
  output logic [31:0]       win_o,
  output tio_pkg::dp_sts_t  sts_o
);
  import tio_pkg::*;

  logic [7:0] mem [SubDepth];
  logic [7:0] rd_q;
  logic [23:0] val_q, val_d;
  logic [3:0] dig_q [8];
  logic [3:0] nd_q, nd_d;
  logic       busy_q, busy_d;
  logic [31:0] win_q;
  logic [23:0] quot;
  logic [3:0]  rem;
  logic [47:0] prod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sub_write) mem[wr_idx_i] <= wr_data_i;
    if (cmd_i.sub_read) rd_q <= mem[cmd_i.rd_idx];
    if (cmd_i.win_latch) win_q <= {win_q[23:0], rd_q};
  end

  // Divide by ten: multiply by reciprocal, then derive the remainder.
  assign prod = val_q * 24'hCCCCCD;
  always_comb begin
    logic [27:0] back;
    quot = {3'd0, prod[47:27]};
    back = {4'd0, quot} * 28'd10;
    rem  = 4'(val_q - back[23:0]);
  end

  always_comb begin
    val_d  = val_q;
    nd_d   = nd_q;
    busy_d = busy_q;
    if (cmd_i.conv_start) begin
      val_d  = (speed_i > SpeedMax) ? SpeedMax : speed_i;
      nd_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q && cmd_i.conv_step) begin
      val_d = quot;
      nd_d  = nd_q + 4'd1;
      if (quot == '0 || nd_q == 4'd7) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      nd_q   <= '0;
      val_q  <= '0;
    end else begin
      busy_q <= busy_d;
      nd_q   <= nd_d;
      val_q  <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && cmd_i.conv_step) dig_q[nd_q[2:0]] <= rem;
  end

  assign dig_char_o      = 8'h30 + {4'd0, dig_q[dig_sel_i]};
  assign win_o           = win_q;
  assign sts_o.rd_data   = rd_q;
  assign sts_o.conv_done = !busy_q;
  assign sts_o.ndig      = nd_q;
endmodule

// ===== rtl/tio_controller.sv =====
// Parser and reply sequencer.
module tio_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic [31:0]       out_win_o,
  output logic              out_last_o,
  input  logic [1:0]        break_mode_i,
  input  logic [63:0]       type_chars_i,
  input  logic [3:0]        type_len_i,
  output tio_pkg::dp_cmd_t  cmd_o,
  output logic [7:0]        wr_data_o,
  output logic [tio_pkg::SubIdxW-1:0] wr_idx_o,
  output logic [2:0]        dig_sel_o,
  input  logic [7:0]        dig_char_i,
  input  logic [31:0]       win_i,
  input  tio_pkg::dp_sts_t  sts_i
);
  import tio_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD0   = 4'd1;
  localparam logic [3:0] ST_RD1   = 4'd2;
  localparam logic [3:0] ST_DEC   = 4'd3;
  localparam logic [3:0] ST_WIN   = 4'd4;
  localparam logic [3:0] ST_REPLY = 4'd5;
  localparam logic [3:0] ST_CONV  = 4'd6;
  localparam logic [3:0] ST_NEG   = 4'd7;

  logic [3:0] st_q, st_d;
  logic [1:0] stage_q, stage_d;
  logic [7:0] verb_q, verb_d;
  logic       insub_q, insub_d, esc_q, esc_d;
  logic [SubIdxW-1:0] cnt_q, cnt_d;
  logic [7:0] opt0_q, opt0_d;
  logic       spd_q, spd_d;
  logic [2:0] win_n_q, win_n_d;
  logic [4:0] seq_q, seq_d;
  logic [1:0] rep_q, rep_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] neg_q, neg_d, nopt_q, nopt_d;
  logic       ov_q, ov_d;
  logic [2:0] okind_q, okind_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic       owin_q, owin_d;
  logic [3:0] tlen;
  logic [7:0] rd_eff;
  logic [7:0] chr;
  src_e       src;
  logic       seq_last;

  assign tlen = (type_len_i > 4'(TypeChars)) ? 4'(TypeChars) : type_len_i;
  assign chr  = type_chars_i[{pos_q[2:0], 3'b000} +: 8];
  assign in_ready_o = (st_q == ST_IDLE) && !(ov_q && !out_ready_i);

  always_comb begin
    st_d = st_q; stage_d = stage_q; verb_d = verb_q; insub_d = insub_q;
    esc_d = esc_q; cnt_d = cnt_q; opt0_d = opt0_q; spd_d = spd_q;
    win_n_d = win_n_q; seq_d = seq_q; rep_d = rep_q; pos_d = pos_q;
    neg_d = neg_q; nopt_d = nopt_q;
    ov_d = ov_q && !out_ready_i;
    okind_d = okind_q; obyte_d = obyte_q; olast_d = olast_q; owin_d = owin_q;
    cmd_o = '0;
    cmd_o.rd_idx = '0;
    wr_data_o = in_byte_i;
    wr_idx_o  = cnt_q;
    dig_sel_o = 3'(pos_q);
    src = SRC_IAC;
    seq_last = 1'b0;
    rd_eff = '0;

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (insub_q) begin
            if (esc_q && in_byte_i == B_SE) begin
              esc_d = 1'b0;
              insub_d = 1'b0; stage_d = 2'd0;
              st_d = ST_RD0;
            end else if (!esc_q && in_byte_i == B_IAC) begin
              esc_d = 1'b1;
            end else begin
              esc_d = 1'b0;
              cmd_o.sub_write = 1'b1;
              cnt_d = cnt_q + 1'b1;
              if (cnt_q == SubIdxW'(SubDepth - 1)) begin
                insub_d = 1'b0; stage_d = 2'd0;
              end
            end
          end else if (stage_q == 2'd1) begin
            stage_d = 2'd0;
            case (in_byte_i)
              B_IAC: begin
                ov_d = 1'b1; okind_d = K_DATA; obyte_d = in_byte_i;
                olast_d = 1'b1; owin_d = 1'b0;
              end
              B_GA, B_DM: ;
              B_SB: begin insub_d = 1'b1; esc_d = 1'b0; cnt_d = '0; end
              B_BRK: begin
                if (break_mode_i == 2'd1 || break_mode_i == 2'd2) begin
                  ov_d = 1'b1; obyte_d = '0; olast_d = 1'b1; owin_d = 1'b0;
                  okind_d = (break_mode_i == 2'd1) ? K_LBRK : K_RBRK;
                end
              end
              B_DO, B_DONT, B_WILL, B_WONT: begin
                verb_d = in_byte_i; stage_d = 2'd2;
              end
              default: begin
                ov_d = 1'b1; okind_d = K_UNEXP; obyte_d = in_byte_i;
                olast_d = 1'b1; owin_d = 1'b0;
              end
            endcase
          end else if (stage_q == 2'd2) begin
            stage_d = 2'd0;
            case (verb_q)
              B_WILL: neg_d = (in_byte_i == OPT_SGA || in_byte_i == OPT_ECHO ||
                               in_byte_i == OPT_TTYPE || in_byte_i == OPT_NAWS)
                              ? B_DO : B_DONT;
              B_WONT: neg_d = B_DONT;
              B_DO:   neg_d = (in_byte_i == OPT_TTYPE || in_byte_i == OPT_BINARY ||
                               in_byte_i == OPT_NAWS || in_byte_i == OPT_SPEED)
                              ? B_WILL : B_WONT;
              default: neg_d = B_WONT;
            endcase
            nopt_d = in_byte_i; seq_d = '0;
            st_d = ST_NEG;
          end else begin
            if (in_byte_i == B_IAC) stage_d = 2'd1;
            else begin
              ov_d = 1'b1; okind_d = K_DATA; obyte_d = in_byte_i;
              olast_d = 1'b1; owin_d = 1'b0;
            end
          end
        end
      end
      ST_NEG: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; okind_d = K_NET; owin_d = 1'b0;
          obyte_d = (seq_q == 5'd0) ? B_IAC : (seq_q == 5'd1) ? neg_q : nopt_q;
          olast_d = (seq_q == 5'd2);
          seq_d = seq_q + 5'd1;
          if (seq_q == 5'd2) st_d = ST_IDLE;
        end
      end
      ST_RD0: begin
        cmd_o.sub_read = 1'b1; cmd_o.rd_idx = '0;
        st_d = ST_RD1;
      end
      ST_RD1: begin
        // rd_q holds entry 0; fetch entry 1.
        rd_eff = (cnt_q > 0) ? sts_i.rd_data : 8'd0;
        opt0_d = rd_eff;
        cmd_o.sub_read = 1'b1; cmd_o.rd_idx = SubIdxW'(1);
        win_n_d = 3'd1;
        st_d = ST_DEC;
      end
      ST_DEC: begin
        rd_eff = (cnt_q > 1) ? sts_i.rd_data : 8'd0;
        seq_d = '0; pos_d = '0; rep_d = '0;
        if (opt0_q == OPT_NAWS) begin
          cmd_o.sub_read = 1'b1; cmd_o.rd_idx = SubIdxW'(2);
          cmd_o.win_latch = 1'b1;
          st_d = ST_WIN; win_n_d = 3'd2;
        end else if (opt0_q == OPT_TTYPE && rd_eff == SUB_SEND) begin
          spd_d = 1'b0; st_d = ST_REPLY;
        end else if (opt0_q == OPT_SPEED && rd_eff == SUB_SEND) begin
          spd_d = 1'b1; cmd_o.conv_start = 1'b1; st_d = ST_CONV;
        end else st_d = ST_IDLE;
      end
      ST_WIN: begin
        // Shift entries 1..4 through the window register; zero past count.
        cmd_o.win_latch = 1'b1;
        cmd_o.sub_read = 1'b1;
        cmd_o.rd_idx = SubIdxW'(win_n_q) + SubIdxW'(1);
        win_n_d = win_n_q + 3'd1;
        if (win_n_q == 3'd4 && (!ov_q || out_ready_i)) begin
          ov_d = 1'b1; okind_d = K_WIN; obyte_d = '0; olast_d = 1'b1; owin_d = 1'b1;
          st_d = ST_IDLE;
        end else if (win_n_q == 3'd4) begin
          cmd_o.win_latch = 1'b0; cmd_o.sub_read = 1'b0; win_n_d = win_n_q;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) begin
          cmd_o.conv_step = 1'b0;
          pos_d = sts_i.ndig - 4'd1;
          st_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        case (seq_q)
          5'd0: src = SRC_IAC;
          5'd1: src = SRC_SB;
          5'd2: src = SRC_OPT;
          5'd3: src = SRC_IS;
          5'd4: src = spd_q ? SRC_DIGIT : SRC_CHAR;
          5'd5: src = SRC_COMMA;
          5'd6: src = SRC_DIGIT;
          5'd7: src = SRC_IAC;
          default: src = SRC_SE;
        endcase
        if (seq_q == 5'd4 && !spd_q && tlen == 4'd0) src = SRC_IAC;
        seq_last = (src == SRC_SE);
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; okind_d = K_NET; owin_d = 1'b0; olast_d = seq_last;
          case (src)
            SRC_IAC:   obyte_d = B_IAC;
            SRC_SB:    obyte_d = B_SB;
            SRC_OPT:   obyte_d = spd_q ? OPT_SPEED : OPT_TTYPE;
            SRC_IS:    obyte_d = SUB_IS;
            SRC_CHAR:  obyte_d = chr;
            SRC_DIGIT: obyte_d = dig_char_i;
            SRC_COMMA: obyte_d = 8'h2C;
            default:   obyte_d = B_SE;
          endcase
          case (src)
            SRC_CHAR: begin
              pos_d = pos_q + 4'd1;
              if (pos_q + 4'd1 >= tlen) seq_d = 5'd7;
            end
            SRC_DIGIT: begin
              if (pos_q == 4'd0) begin
                pos_d = sts_i.ndig - 4'd1;
                seq_d = (seq_q == 5'd4) ? 5'd5 : 5'd7;
              end else pos_d = pos_q - 4'd1;
            end
            SRC_IAC: seq_d = (seq_q == 5'd0) ? 5'd1 : 5'd8;
            SRC_SE:  st_d = ST_IDLE;
            default: seq_d = seq_q + 5'd1;
          endcase
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Zero window entries beyond the collected count on the way out of the register.
  logic [31:0] win_fix;
  always_comb begin
    win_fix = win_i;
    if (cnt_q < 5) win_fix[7:0]   = '0;
    if (cnt_q < 4) win_fix[15:8]  = '0;
    if (cnt_q < 3) win_fix[23:16] = '0;
    if (cnt_q < 2) win_fix[31:24] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; stage_q <= '0; verb_q <= '0; insub_q <= 1'b0; esc_q <= 1'b0;
      cnt_q <= '0; ov_q <= 1'b0; seq_q <= '0; rep_q <= '0; pos_q <= '0;
      win_n_q <= '0; spd_q <= 1'b0;
    end else begin
      st_q <= st_d; stage_q <= stage_d; verb_q <= verb_d; insub_q <= insub_d;
      esc_q <= esc_d; cnt_q <= cnt_d; ov_q <= ov_d; seq_q <= seq_d; rep_q <= rep_d;
      pos_q <= pos_d; win_n_q <= win_n_d; spd_q <= spd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opt0_q <= opt0_d; neg_q <= neg_d; nopt_q <= nopt_d;
    okind_q <= okind_d; obyte_q <= obyte_d; olast_q <= olast_d; owin_q <= owin_d;
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_byte_o  = obyte_q;
  assign out_win_o   = owin_q ? win_fix : 32'd0;
  assign out_last_o  = olast_q;
endmodule

// ===== rtl/telnet_iac_option_negotiator_unit.sv =====
// Telnet receive parser: one network byte per accepted word on s_axis. Plain data,
// IAC IAC, unexpected commands and enabled breaks give a single result word; the
// next byte is accepted once it is taken (one byte per cycle when the master keeps
// up). A WILL/WONT/DO/DONT option byte yields three reply words, one per cycle
// while the master keeps up. Ending a subnegotiation with IAC SE reads the first
// buffer entries, then shifts entries 1..4 into the window register for a window
// size result, or converts the speed to decimal, one divide-by-ten step per digit;
// replies go out one word per cycle while the master keeps up (up to 21 words).
// Input is held off while a reply is sequenced. cfg_* writes take effect at once.
module telnet_iac_option_negotiator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [23:8] window_columns,
                                      // [39:24] window_lines
  output logic [2:0]  m_axis_tuser,   // [2:0] out_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import tio_pkg::*;
`include "telnet_iac_option_negotiator_unit_macros.svh"

  logic [1:0]  brk_q;
  logic [63:0] tchars_q;
  logic [3:0]  tlen_q;
  logic [23:0] speed_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [7:0]  wr_data, dig_char;
  logic [SubIdxW-1:0] wr_idx;
  logic [2:0]  dig_sel;
  logic [31:0] win_raw, win_out;
  logic [7:0]  obyte;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q <= '0; tchars_q <= '0; tlen_q <= '0; speed_q <= DefaultSpeed;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BREAK_MODE: brk_q    <= cfg_data_i[1:0];
        REG_TYPE_CHARS: tchars_q <= cfg_data_i;
        REG_TYPE_LEN:   tlen_q   <= cfg_data_i[3:0];
        REG_SPEED:      speed_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  tio_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_byte_i(s_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_byte_o(obyte), .out_win_o(win_out),
    .out_last_o(m_axis_tlast),
    .break_mode_i(brk_q), .type_chars_i(tchars_q), .type_len_i(tlen_q),
    .cmd_o(cmd), .wr_data_o(wr_data), .wr_idx_o(wr_idx), .dig_sel_o(dig_sel),
    .dig_char_i(dig_char), .win_i(win_raw), .sts_i(sts)
  );

  tio_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .wr_data_i(wr_data), .wr_idx_i(wr_idx),
    .speed_i(speed_q), .dig_sel_i(dig_sel), .dig_char_o(dig_char),
    .win_o(win_raw), .sts_o(sts)
  );

  assign m_axis_tdata = {8'd0, win_out[15:0], win_out[31:16], obyte};

  // Stalled result must hold; window fields only on window words.
  `TIO_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `TIO_ASSERT_IMPL(a_win, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != K_WIN,
                   m_axis_tdata[39:8] == 32'd0)
  `TIO_ASSERT_IMPL(a_busy, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast,
                   !s_axis_tready)
endmodule
